// ===== src/lpwe_pkg.sv =====
// Shared types and constants for the LED pulse-width bit encoder.
// No dependencies; imported by every module of the encoder.
`default_nettype none

package lpwe_pkg;

    // Field and register widths.
    localparam int BYTE_W          = 8;
    localparam int BIT_IDX_W       = 3;
    localparam int REG_W           = 16;
    localparam int COUNT_WIDTH_DEF = 16;

    // Index of the last bit of a byte.
    localparam logic [BIT_IDX_W-1:0] LAST_BIT_IDX = 3'd7;

    // Register reset values.
    localparam logic [REG_W-1:0] SHORT_TICKS_RST = 16'd24;
    localparam logic [REG_W-1:0] LONG_TICKS_RST  = 16'd87;

    // Configuration register indexes.
    typedef enum logic {
        CFG_SHORT_TICKS = 1'b0,
        CFG_LONG_TICKS  = 1'b1
    } t_cfg_idx;

    // Item kind.
    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_LOAD = 1'b1
    } t_kind;

    // Classified item as it sits in the queue.
    typedef struct packed {
        logic               is_load;
        logic [BYTE_W-1:0]  data_byte;
        logic               last_byte;
    } t_cmd;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_slot;

    // One result item.
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic rejected;
        logic stream_done;
    } t_res;

endpackage

`default_nettype wire

// ===== src/lpwe_front.sv =====
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on lpwe_pkg.
`default_nettype none

module lpwe_front
    import lpwe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_kind,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_last_byte,
    output t_cmd_slot              o_head,
    input  wire logic              i_pop
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;
    t_cmd       w_cmd;

    // Classify the incoming item.
    always_comb begin
        w_cmd.is_load   = (t_kind'(i_kind) == KIND_LOAD);
        w_cmd.data_byte = i_data_byte;
        w_cmd.last_byte = i_last_byte;
    end

    assign o_ready = (r_count != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = i_pop && (r_count != 2'd0);

    // Queue pointers and fill count.
    always_comb begin
        n_wr_ptr = w_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = w_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_cmd;
        end
    end

    // Present the oldest item.
    always_comb begin
        o_head.valid = (r_count != 2'd0);
        o_head.cmd   = r_mem[r_rd_ptr];
    end

endmodule

`default_nettype wire

// ===== src/lpwe_back.sv =====
// Back end: phase timers and bit shifter; runs one queued item per cycle unless
// its result register is held full; registers the result. Depends on lpwe_pkg.
`default_nettype none

module lpwe_back
    import lpwe_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [REG_W-1:0] i_cfg_data,
    input  t_cmd_slot             i_head,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_res                  o_res
);

    localparam int LEN_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
    localparam logic [LEN_W-1:0] CNT_MAX = LEN_W'({COUNT_WIDTH{1'b1}});
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    // Phase length: clamp to the counter range, and treat zero as one.
    function automatic logic [COUNT_WIDTH-1:0] phase_len(input logic [REG_W-1:0] v);
        logic [LEN_W-1:0] ext;
        logic [LEN_W-1:0] sat;
        ext = LEN_W'(v);
        sat = (ext > CNT_MAX) ? CNT_MAX : ext;
        if (sat == '0) begin
            sat = LEN_W'(1);
        end
        return sat[COUNT_WIDTH-1:0];
    endfunction

    logic [REG_W-1:0]       r_short_ticks;
    logic [REG_W-1:0]       r_long_ticks;
    logic [BYTE_W-1:0]      r_shift_byte;
    logic [BIT_IDX_W-1:0]   r_bit_index;
    logic                   r_in_low_phase;
    logic [COUNT_WIDTH-1:0] r_phase_count;
    logic                   r_active;
    logic                   r_final_flag;
    logic                   r_out_valid;
    t_res                   r_res;

    logic [BYTE_W-1:0]      n_shift_byte;
    logic [BIT_IDX_W-1:0]   n_bit_index;
    logic                   n_in_low_phase;
    logic [COUNT_WIDTH-1:0] n_phase_count;
    logic                   n_active;
    logic                   n_final_flag;
    t_res                   n_res;

    logic [COUNT_WIDTH-1:0] w_short_len;
    logic [COUNT_WIDTH-1:0] w_long_len;
    logic [COUNT_WIDTH-1:0] w_len;
    logic [COUNT_WIDTH-1:0] w_count_inc;
    logic                   w_phase_end;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_ticks <= SHORT_TICKS_RST;
            r_long_ticks  <= LONG_TICKS_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SHORT_TICKS: r_short_ticks <= i_cfg_data;
                CFG_LONG_TICKS:  r_long_ticks  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Take the next item whenever the output register is free or being emptied.
    assign o_pop = i_head.valid && (!r_out_valid || i_ready);

    // Length of the running phase: long when the bit and the phase disagree.
    assign w_short_len = phase_len(r_short_ticks);
    assign w_long_len  = phase_len(r_long_ticks);
    assign w_len       = (r_shift_byte[BYTE_W-1] ^ r_in_low_phase) ? w_long_len : w_short_len;
    assign w_count_inc = r_phase_count + CNT_ONE;
    assign w_phase_end = (w_count_inc >= w_len);

    // Execute the item at the queue head.
    always_comb begin
        n_shift_byte      = r_shift_byte;
        n_bit_index       = r_bit_index;
        n_in_low_phase    = r_in_low_phase;
        n_phase_count     = r_phase_count;
        n_active          = r_active;
        n_final_flag      = r_final_flag;
        n_res.rejected    = 1'b0;
        n_res.stream_done = 1'b0;
        if (i_head.cmd.is_load) begin
            if (r_active) begin
                n_res.rejected = 1'b1;
            end else begin
                n_shift_byte   = i_head.cmd.data_byte;
                n_final_flag   = i_head.cmd.last_byte;
                n_bit_index    = '0;
                n_in_low_phase = 1'b0;
                n_phase_count  = '0;
                n_active       = 1'b1;
            end
        end else if (r_active) begin
            n_phase_count = w_count_inc;
            if (w_phase_end) begin
                n_phase_count = '0;
                if (!r_in_low_phase) begin
                    n_in_low_phase = 1'b1;
                end else if (r_bit_index == LAST_BIT_IDX) begin
                    n_active          = 1'b0;
                    n_in_low_phase    = 1'b0;
                    n_bit_index       = '0;
                    n_res.stream_done = r_final_flag;
                    n_final_flag      = 1'b0;
                end else begin
                    n_bit_index    = r_bit_index + 3'd1;
                    n_shift_byte   = {r_shift_byte[BYTE_W-2:0], 1'b0};
                    n_in_low_phase = 1'b0;
                end
            end
        end
        n_res.pin_level = n_active && !n_in_low_phase;
        n_res.busy_res  = n_active;
    end

    // Encoder state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_byte   <= '0;
            r_bit_index    <= '0;
            r_in_low_phase <= 1'b0;
            r_phase_count  <= '0;
            r_active       <= 1'b0;
            r_final_flag   <= 1'b0;
        end else if (o_pop) begin
            r_shift_byte   <= n_shift_byte;
            r_bit_index    <= n_bit_index;
            r_in_low_phase <= n_in_low_phase;
            r_phase_count  <= n_phase_count;
            r_active       <= n_active;
            r_final_flag   <= n_final_flag;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== src/led_pulse_width_bit_encoder.sv =====
// Top level of the LED pulse-width bit encoder: front end with item queue and
// back end with timers and output register. Depends on lpwe_pkg, lpwe_front, lpwe_back.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+----------------------------------------------
//  input    | i_valid / o_ready    | i_kind, i_data_byte, i_last_byte
//  output   | o_valid / i_ready    | o_pin_level, o_busy_res, o_rejected, o_stream_done
//  config   | i_cfg_we             | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while results are taken; a taken item is written into
// the two-entry queue and, once the back end pops it, is executed straight into the
// back end's output register.
// The back end executes one queued item per cycle; it pauses only while its result
// register is full and not being taken, and the input stalls only when the queue is full.
// Reset is synchronous and active low; it clears the queue, the encoder state and
// restores the phase lengths to 24 and 87 ticks.
`default_nettype none

module led_pulse_width_bit_encoder
    import lpwe_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic              i_cfg_index,
    input  wire logic [REG_W-1:0]  i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_kind,
    input  wire logic [BYTE_W-1:0] i_data_byte,
    input  wire logic              i_last_byte,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic                   o_pin_level,
    output logic                   o_busy_res,
    output logic                   o_rejected,
    output logic                   o_stream_done
);

    t_cmd_slot w_head;
    logic      w_pop;
    t_res      w_res;

    // Front end and item queue.
    lpwe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_kind      (i_kind),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_head      (w_head),
        .i_pop       (w_pop)
    );

    // Back end with timers and result register.
    lpwe_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (w_res)
    );

    // Result fields.
    assign o_pin_level   = w_res.pin_level;
    assign o_busy_res    = w_res.busy_res;
    assign o_rejected    = w_res.rejected;
    assign o_stream_done = w_res.stream_done;

endmodule

`default_nettype wire

// ===== bench/tb_led_pulse_width_bit_encoder.sv =====
// Self-checking bench for the LED pulse-width bit encoder: directed and random items,
// predicted per accepted item and compared field by field against every result item.
// Depends on lpwe_pkg and led_pulse_width_bit_encoder.
`default_nettype none

module tb_led_pulse_width_bit_encoder;
    import lpwe_pkg::*;

    // One input item as it waits in the driver queue.
    typedef struct {
        t_kind             kind;
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } t_item;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_index = 1'b0;
    logic [REG_W-1:0]  i_cfg_data  = '0;
    logic              i_valid     = 1'b0;
    logic              i_kind      = 1'b0;
    logic [BYTE_W-1:0] i_data_byte = '0;
    logic              i_last_byte = 1'b0;
    logic              i_ready     = 1'b0;
    logic              o_ready;
    logic              o_valid;
    logic              o_pin_level;
    logic              o_busy_res;
    logic              o_rejected;
    logic              o_stream_done;

    led_pulse_width_bit_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_pin_level  (o_pin_level),
        .o_busy_res   (o_busy_res),
        .o_rejected   (o_rejected),
        .o_stream_done(o_stream_done)
    );

    // Driver and scoreboard bookkeeping.
    t_item pending_items[$];
    t_res  expected_levels[$];
    int    pushed_cnt   = 0;
    int    accepted_cnt = 0;
    int    err_count    = 0;
    logic  in_taken     = 1'b0;
    int    burst_left   = 0;
    int    gap_left     = 0;
    int    ready_cycle  = 0;

    // Encoder copy: phase lengths and serializer state.
    logic [REG_W-1:0]           short_reg = SHORT_TICKS_RST;
    logic [REG_W-1:0]           long_reg  = LONG_TICKS_RST;
    logic [BYTE_W-1:0]          enc_byte  = '0;
    logic [BIT_IDX_W-1:0]       enc_bit   = '0;
    logic                       enc_low   = 1'b0;
    logic [COUNT_WIDTH_DEF-1:0] enc_count = '0;
    logic                       enc_active = 1'b0;
    logic                       enc_final  = 1'b0;

    // Clock generation.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic report(string msg);
        err_count++;
        if (err_count <= 40) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic got, logic want);
        if (got !== want) report($sformatf("%s is %b, expected %b", name, got, want));
    endtask

    // Phase length in ticks: zero behaves as one, and the counter range caps it.
    function automatic longint unsigned phase_ticks(logic [REG_W-1:0] r);
        longint unsigned len;
        longint unsigned lim;
        lim = (longint'(1) << COUNT_WIDTH_DEF) - 1;
        len = r;
        if (len > lim) len = lim;
        if (len == 0) len = 1;
        return len;
    endfunction

    // Advance the encoder copy by one item and queue the line state it leads to.
    task automatic encode_item(t_item it);
        t_res            res;
        logic            bit_val;
        longint unsigned len;
        res = '0;
        if (it.kind == KIND_LOAD) begin
            if (enc_active) begin
                res.rejected = 1'b1;
            end else begin
                enc_byte   = it.data_byte;
                enc_final  = it.last_byte;
                enc_bit    = '0;
                enc_low    = 1'b0;
                enc_count  = '0;
                enc_active = 1'b1;
            end
        end else if (enc_active) begin
            bit_val = enc_byte[LAST_BIT_IDX - enc_bit];
            // A one bit is long high then short low; a zero bit the other way round.
            len = (bit_val != enc_low) ? phase_ticks(long_reg) : phase_ticks(short_reg);
            enc_count = enc_count + 1'b1;
            if (enc_count >= len) begin
                enc_count = '0;
                if (!enc_low) begin
                    enc_low = 1'b1;
                end else if (enc_bit == LAST_BIT_IDX) begin
                    enc_active = 1'b0;
                    enc_low    = 1'b0;
                    enc_bit    = '0;
                    res.stream_done = enc_final;
                    enc_final  = 1'b0;
                end else begin
                    enc_bit = enc_bit + 1'b1;
                    enc_low = 1'b0;
                end
            end
        end
        res.pin_level = enc_active && !enc_low;
        res.busy_res  = enc_active;
        expected_levels.push_back(res);
    endtask

    function automatic void push_item(t_kind k, logic [BYTE_W-1:0] d, logic last);
        t_item it;
        it.kind      = k;
        it.data_byte = d;
        it.last_byte = last;
        pending_items.push_back(it);
        pushed_cnt++;
    endfunction

    function automatic void push_tick();
        push_item(KIND_TICK, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endfunction

    // Wait until every item has gone in and every result has come out.
    task automatic drain();
        while (accepted_cnt != pushed_cnt || expected_levels.size() != 0) @(negedge i_clk);
    endtask

    // Program both phase lengths once the block is idle.
    task automatic set_lengths(logic [REG_W-1:0] s, logic [REG_W-1:0] l);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SHORT_TICKS;
        i_cfg_data  <= s;
        short_reg = s;
        @(negedge i_clk);
        i_cfg_index <= CFG_LONG_TICKS;
        i_cfg_data  <= l;
        long_reg = l;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Driver: presents queued items in bursts with random gaps between them.
    always @(negedge i_clk) begin : drive_items
        t_item it;
        if (i_rst_n) begin
            if (i_valid && !in_taken) begin
                // Hold the item until it is accepted.
            end else if (gap_left > 0) begin
                i_valid <= 1'b0;
                gap_left--;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                i_valid     <= 1'b1;
                i_kind      <= it.kind;
                i_data_byte <= it.data_byte;
                i_last_byte <= it.last_byte;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    gap_left   = $urandom_range(0, 4);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: steps through four stall patterns: always ready, random, a repeating on/off pattern, mostly ready.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            ready_cycle++;
            case ((ready_cycle / 97) % 4)
                0: i_ready <= 1'b1;
                1: i_ready <= 1'($urandom_range(0, 1));
                2: i_ready <= (ready_cycle % 7) >= 3;
                default: i_ready <= $urandom_range(0, 9) != 0;
            endcase
        end
    end

    // Monitor: checks each result item and predicts each accepted input item.
    always @(posedge i_clk) begin : monitor
        t_res  want;
        t_item it;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_levels.size() == 0) begin
                    report("result item with no expectation waiting");
                end else begin
                    want = expected_levels.pop_front();
                    check_field("pin_level", o_pin_level, want.pin_level);
                    check_field("busy_res", o_busy_res, want.busy_res);
                    check_field("rejected", o_rejected, want.rejected);
                    check_field("stream_done", o_stream_done, want.stream_done);
                end
            end
            if (i_valid && o_ready) begin
                in_taken = 1'b1;
                accepted_cnt++;
                it.kind      = t_kind'(i_kind);
                it.data_byte = i_data_byte;
                it.last_byte = i_last_byte;
                encode_item(it);
            end
        end
    end

    // Stimulus sequence.
    initial begin : stimulus
        int               ph;
        int               n;
        int               sel;
        int               span;
        int               k;
        logic [REG_W-1:0] s;
        logic [REG_W-1:0] l;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset lengths: tick while idle, a load, a load while busy, a few ticks.
        push_item(KIND_TICK, 8'hFF, 1'b1);
        push_item(KIND_LOAD, 8'h80, 1'b1);
        push_item(KIND_LOAD, 8'h55, 1'b1);
        push_tick();
        push_tick();

        // Zero-length short phase: finish the byte and see the done pulse.
        set_lengths(16'd0, 16'd1);
        for (k = 0; k < 16; k++) push_tick();

        // Largest lengths: load zeros, get a rejected load, a couple of ticks.
        set_lengths(16'hFFFF, 16'hFFFF);
        push_item(KIND_LOAD, 8'h00, 1'b0);
        push_item(KIND_LOAD, 8'hFF, 1'b1);
        push_tick();
        push_tick();

        // Random phases, mostly whole bytes with short phase lengths.
        for (ph = 0; ph < 6; ph++) begin
            s = (ph == 0) ? 16'd1 : REG_W'($urandom_range(1, 4));
            l = (ph == 0) ? 16'd1 : REG_W'($urandom_range(1, 6));
            set_lengths(s, l);
            n = 0;
            while (n < 150) begin
                sel = $urandom_range(0, 9);
                if (sel < 7) begin
                    push_item(KIND_LOAD, BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                    n++;
                    span = 8 * int'(phase_ticks(s) + phase_ticks(l)) + $urandom_range(0, 2);
                    // Some runs stop early so that the next load lands while busy.
                    if (sel == 6) span = $urandom_range(1, span);
                    for (k = 0; k < span; k++) begin
                        push_tick();
                        n++;
                        if ($urandom_range(0, 15) == 0) begin
                            push_item(KIND_LOAD, BYTE_W'($urandom_range(0, 255)),
                                      1'($urandom_range(0, 1)));
                            n++;
                        end
                    end
                end else if (sel < 9) begin
                    span = $urandom_range(1, 4);
                    for (k = 0; k < span; k++) push_tick();
                    n += span;
                end else begin
                    push_item(KIND_LOAD, BYTE_W'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)));
                    n++;
                end
            end
        end

        // Let everything drain, then keep watching for stray results before the final check.
        drain();
        repeat (20) @(negedge i_clk);
        if (expected_levels.size() != 0) report("expected results left over at the end");
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
